// ----- sv/hrdp_pkg.sv -----
package hrdp_pkg;

    // field widths
    localparam int RES_W = 14;
    localparam int Z_W = 32;
    localparam int PHI_W = 32;
    localparam int SIN_W = 31;
    localparam int PIX_W = 30;

    // number formats
    localparam int MAX_RESOLUTION = 8192;
    localparam int FRAC_BITS = 30;
    localparam int TT_W = 32;          // quarter turns in [0,4), FRAC_BITS fraction bits
    localparam int ZA_W = 31;          // |z| up to one
    localparam int G_W = 32;           // cap radicand before scaling
    localparam int DIVIDEND_W = 62;
    localparam int Q_W = 32;           // quotient and root width
    localparam int DEF_STEPS = 2;      // digit steps per stage in divider and root

    localparam logic [31:0] TWO_OVER_PI = 32'hA2F9836E;
    localparam logic [ZA_W-1:0] ONE_Q = ZA_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [RES_W-1:0] n;
        logic [TT_W-1:0]  tt;
        logic [ZA_W-1:0]  za;
        logic             zneg;
        logic             zpos;
        logic             equ;
    } t_ctx;

    typedef struct packed {
        t_ctx           ctx;
        logic           use_div;
        logic [G_W-1:0] g_lin;
    } t_dtag;

    localparam int CTX_W = $bits(t_ctx);
    localparam int DTAG_W = $bits(t_dtag);

endpackage

// ----- sv/hrdp_front.sv -----
module hrdp_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [hrdp_pkg::RES_W-1:0]     i_resolution,
    input  logic signed [hrdp_pkg::Z_W-1:0]   i_cos_colatitude,
    input  logic signed [hrdp_pkg::PHI_W-1:0] i_azimuth,
    input  logic [hrdp_pkg::SIN_W-1:0]     i_sin_colatitude,
    input  logic                           i_sin_valid,
    output logic                           o_valid,
    output logic [hrdp_pkg::DIVIDEND_W-1:0] o_dividend,
    output logic [hrdp_pkg::Q_W-1:0]       o_divisor,
    output hrdp_pkg::t_dtag                o_tag
);
    import hrdp_pkg::*;

    // stage 1: sanitize inputs
    logic [31:0]      zraw, za32, praw, pm;
    logic             zneg, pneg;
    logic [RES_W-1:0] n_n;
    logic [ZA_W-1:0]  n_za;
    logic [SIN_W-1:0] n_sth;

    assign zraw = i_cos_colatitude;
    assign praw = i_azimuth;
    assign zneg = zraw[31];
    assign pneg = praw[31];
    assign za32 = zneg ? (32'd0 - zraw) : zraw;
    assign pm   = pneg ? (32'd0 - praw) : praw;

    always_comb begin
        if (i_resolution == '0) begin
            n_n = RES_W'(1);
        end else if (i_resolution > RES_W'(MAX_RESOLUTION)) begin
            n_n = RES_W'(MAX_RESOLUTION);
        end else begin
            n_n = i_resolution;
        end
        n_za  = (za32 > 32'(ONE_Q)) ? ONE_Q : za32[ZA_W-1:0];
        n_sth = (i_sin_colatitude > SIN_W'(ONE_Q)) ? SIN_W'(ONE_Q) : i_sin_colatitude;
    end

    logic             r1_v, r1_zneg, r1_zpos, r1_pneg, r1_sv;
    logic [RES_W-1:0] r1_n;
    logic [ZA_W-1:0]  r1_za;
    logic [SIN_W-1:0] r1_sth;
    logic [31:0]      r1_pm;

    // stage 2: products and region tests
    logic             r2_v, r2_zneg, r2_zpos, r2_pneg, r2_equ, r2_use_div;
    logic [RES_W-1:0] r2_n;
    logic [ZA_W-1:0]  r2_za;
    logic [63:0]      r2_prod;
    logic [61:0]      r2_sq;
    logic [G_W-1:0]   r2_glin;
    logic [Q_W-1:0]   r2_divisor;

    // stage 3: reduce phi, form dividend
    logic [61:0]      rr, rn;
    logic             r3_v;
    t_dtag            r3_tag;
    logic [DIVIDEND_W-1:0] r3_dividend;
    logic [Q_W-1:0]   r3_divisor;

    assign rr = r2_prod[61:0];
    assign rn = r2_pneg ? (62'd0 - rr) : rr;

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_n    <= n_n;
            r1_za   <= n_za;
            r1_zneg <= zneg;
            r1_zpos <= !zneg && (zraw != 32'd0);
            r1_sth  <= n_sth;
            r1_pm   <= pm;
            r1_pneg <= pneg;
            r1_sv   <= i_sin_valid;

            r2_n       <= r1_n;
            r2_za      <= r1_za;
            r2_zneg    <= r1_zneg;
            r2_zpos    <= r1_zpos;
            r2_pneg    <= r1_pneg;
            r2_prod    <= 64'(r1_pm) * 64'(TWO_OVER_PI);
            r2_sq      <= 62'(r1_sth) * 62'(r1_sth);
            r2_equ     <= (33'(r1_za) * 33'd3) <= (33'd1 << 31);
            r2_use_div <= r1_sv && ((38'(r1_za) * 38'd100) >= (38'd99 << FRAC_BITS));
            r2_glin    <= 32'(ONE_Q - r1_za) * 32'd3;
            r2_divisor <= 32'(ONE_Q) + 32'(r1_za);

            r3_tag.ctx.n    <= r2_n;
            r3_tag.ctx.tt   <= rn[61:FRAC_BITS];
            r3_tag.ctx.za   <= r2_za;
            r3_tag.ctx.zneg <= r2_zneg;
            r3_tag.ctx.zpos <= r2_zpos;
            r3_tag.ctx.equ  <= r2_equ;
            r3_tag.use_div  <= r2_use_div;
            r3_tag.g_lin    <= r2_glin;
            r3_dividend     <= r2_sq * 62'd3;
            r3_divisor      <= r2_divisor;
        end
    end

    assign o_valid    = r3_v;
    assign o_dividend = r3_dividend;
    assign o_divisor  = r3_divisor;
    assign o_tag      = r3_tag;

endmodule

// ----- sv/hrdp_div.sv -----
module hrdp_div #(
    parameter int STEPS_PER_STAGE = hrdp_pkg::DEF_STEPS,
    parameter int TAG_W = hrdp_pkg::DTAG_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [hrdp_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [hrdp_pkg::Q_W-1:0]        i_divisor,
    input  logic [TAG_W-1:0]                i_tag,
    output logic                            o_valid,
    output logic [hrdp_pkg::Q_W-1:0]        o_quot,
    output logic [TAG_W-1:0]                o_tag
);
    import hrdp_pkg::*;

    localparam int NSTG = Q_W / STEPS_PER_STAGE;

    logic             r_v   [NSTG];
    logic [Q_W-1:0]   r_rem [NSTG];
    logic [Q_W-1:0]   r_low [NSTG];
    logic [Q_W-1:0]   r_q   [NSTG];
    logic [Q_W-1:0]   r_d   [NSTG];
    logic [TAG_W-1:0] r_tag [NSTG];

    logic [2*Q_W-1:0] ext;
    assign ext = (2*Q_W)'(i_dividend);

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic             a_v;
        logic [Q_W-1:0]   a_rem, a_low, a_q, a_d;
        logic [TAG_W-1:0] a_tag;
        logic [Q_W-1:0]   n_rem, n_low, n_q;

        if (s == 0) begin : g_first
            assign a_v   = i_valid;
            assign a_rem = ext[2*Q_W-1:Q_W];
            assign a_low = ext[Q_W-1:0];
            assign a_q   = '0;
            assign a_d   = i_divisor;
            assign a_tag = i_tag;
        end else begin : g_next
            assign a_v   = r_v[s-1];
            assign a_rem = r_rem[s-1];
            assign a_low = r_low[s-1];
            assign a_q   = r_q[s-1];
            assign a_d   = r_d[s-1];
            assign a_tag = r_tag[s-1];
        end

        // shift in dividend bits, subtract where the divisor fits
        always_comb begin
            logic [Q_W:0] trial;
            n_rem = a_rem;
            n_low = a_low;
            n_q   = a_q;
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                trial = {n_rem, n_low[Q_W-1]};
                n_low = n_low << 1;
                if (trial >= {1'b0, a_d}) begin
                    n_rem = Q_W'(trial - {1'b0, a_d});
                    n_q   = {n_q[Q_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[Q_W-1:0];
                    n_q   = {n_q[Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_low[s] <= n_low;
                r_q[s]   <= n_q;
                r_d[s]   <= a_d;
                r_tag[s] <= a_tag;
            end
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_quot  = r_q[NSTG-1];
    assign o_tag   = r_tag[NSTG-1];

endmodule

// ----- sv/hrdp_sqrt.sv -----
module hrdp_sqrt #(
    parameter int STEPS_PER_STAGE = hrdp_pkg::DEF_STEPS,
    parameter int TAG_W = hrdp_pkg::CTX_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [2*hrdp_pkg::Q_W-1:0] i_radicand,
    input  logic [TAG_W-1:0]           i_tag,
    output logic                       o_valid,
    output logic [hrdp_pkg::Q_W-1:0]   o_root,
    output logic [TAG_W-1:0]           o_tag
);
    import hrdp_pkg::*;

    localparam int NSTG = Q_W / STEPS_PER_STAGE;
    localparam int REM_W = Q_W + 2;

    logic             r_v   [NSTG];
    logic [REM_W-1:0] r_rem [NSTG];
    logic [2*Q_W-1:0] r_rad [NSTG];
    logic [Q_W-1:0]   r_q   [NSTG];
    logic [TAG_W-1:0] r_tag [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic             a_v;
        logic [REM_W-1:0] a_rem, n_rem;
        logic [2*Q_W-1:0] a_rad, n_rad;
        logic [Q_W-1:0]   a_q, n_q;
        logic [TAG_W-1:0] a_tag;

        if (s == 0) begin : g_first
            assign a_v   = i_valid;
            assign a_rem = '0;
            assign a_rad = i_radicand;
            assign a_q   = '0;
            assign a_tag = i_tag;
        end else begin : g_next
            assign a_v   = r_v[s-1];
            assign a_rem = r_rem[s-1];
            assign a_rad = r_rad[s-1];
            assign a_q   = r_q[s-1];
            assign a_tag = r_tag[s-1];
        end

        // bring down two radicand bits, try root*4+1
        always_comb begin
            logic [REM_W+1:0] rem4;
            logic [REM_W+1:0] trial;
            n_rem = a_rem;
            n_rad = a_rad;
            n_q   = a_q;
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                rem4  = {n_rem, n_rad[2*Q_W-1:2*Q_W-2]};
                n_rad = n_rad << 2;
                trial = (REM_W+2)'({n_q, 2'b01});
                if (rem4 >= trial) begin
                    n_rem = REM_W'(rem4 - trial);
                    n_q   = {n_q[Q_W-2:0], 1'b1};
                end else begin
                    n_rem = REM_W'(rem4);
                    n_q   = {n_q[Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_rad[s] <= n_rad;
                r_q[s]   <= n_q;
                r_tag[s] <= a_tag;
            end
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_root  = r_q[NSTG-1];
    assign o_tag   = r_tag[NSTG-1];

endmodule

// ----- sv/hrdp_back.sv -----
module hrdp_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [hrdp_pkg::Q_W-1:0]  i_root,
    input  hrdp_pkg::t_ctx            i_ctx,
    output logic                      o_valid,
    output logic [hrdp_pkg::PIX_W-1:0] o_pixel
);
    import hrdp_pkg::*;

    logic r_v [6];

    // stage 1: scale root by nside, equator edge-line terms
    t_ctx        r1_ctx;
    logic [45:0] r1_tmp;
    logic [48:0] r1_t1;
    logic [45:0] r1_t2;
    logic [34:0] tt4;
    assign tt4 = 35'({i_ctx.tt, 2'b00}) + (35'd1 << 31);

    // stage 2: partial products of the cap edge lines, equator floors
    t_ctx        r2_ctx;
    logic [61:0] r2_pa_lo;
    logic [43:0] r2_pa_hi;
    logic [62:0] r2_pb_lo;
    logic [44:0] r2_pb_hi;
    logic [17:0] r2_jp_e, r2_jm_e;
    logic [29:0] tp;
    logic [30:0] omtp;
    logic [49:0] sum_e, diff_e, dm_e, dp_e;
    assign tp     = r1_ctx.tt[FRAC_BITS-1:0];
    assign omtp   = ONE_Q - 31'(tp);
    assign sum_e  = 50'(r1_t1) + 50'(r1_t2);
    assign diff_e = (r1_t1 >= 49'(r1_t2)) ? 50'(r1_t1 - 49'(r1_t2)) : 50'd0;
    assign dm_e   = r1_ctx.zneg ? sum_e : diff_e;
    assign dp_e   = r1_ctx.zneg ? diff_e : sum_e;

    // stage 3: cap floors, equator ring
    t_ctx        r3_ctx;
    logic [17:0] r3_jp_p, r3_jm_p, r3_jp_e, r3_jm_e;
    logic [14:0] r3_ir_e;
    logic [77:0] sa, sb;
    logic [19:0] up_e, dif_e;
    logic [14:0] ir_e;
    assign sa    = 78'(r2_pa_lo) + (78'(r2_pa_hi) << 32);
    assign sb    = 78'(r2_pb_lo) + (78'(r2_pb_hi) << 32);
    assign up_e  = 20'(r2_ctx.n) + 20'd1 + 20'(r2_jp_e);
    assign dif_e = up_e - 20'(r2_jm_e);
    always_comb begin
        if (up_e <= 20'(r2_jm_e)) begin
            ir_e = 15'd1;
        end else if (dif_e > 20'({r2_ctx.n, 1'b1})) begin
            ir_e = {r2_ctx.n, 1'b1};
        end else begin
            ir_e = dif_e[14:0];
        end
    end

    // stage 4: cap ring, equator position before wrap
    t_ctx        r4_ctx;
    logic [RES_W-1:0] r4_ir_p;
    logic [14:0] r4_ir_e;
    logic [19:0] r4_h_e;
    logic [18:0] irs_p;
    logic [20:0] s_e;
    assign irs_p = 19'(r3_jp_p) + 19'(r3_jm_p) + 19'd1;
    assign s_e   = 21'(r3_jp_e) + 21'(r3_jm_e) + 21'(!r3_ir_e[0]) + 21'd1
                 + (21'(r3_ctx.n) << 3) - 21'(r3_ctx.n);

    // stage 5: products for ring offsets, wrap equator position
    t_ctx        r5_ctx;
    logic [RES_W-1:0] r5_ir_p;
    logic [15:0] r5_ip_p, r5_ip_e;
    logic [27:0] r5_irsq;
    logic [26:0] r5_nn;
    logic [28:0] r5_irn;
    logic [45:0] ttir;
    logic [19:0] n4, n8;
    logic [15:0] ip_e;
    assign ttir = 46'(r4_ctx.tt) * 46'(r4_ir_p);
    assign n4   = 20'(r4_ctx.n) << 2;
    assign n8   = 20'(r4_ctx.n) << 3;
    always_comb begin
        if (r4_h_e >= n8) begin
            ip_e = 16'(r4_h_e - n8);
        end else if (r4_h_e >= n4) begin
            ip_e = 16'(r4_h_e - n4);
        end else begin
            ip_e = 16'(r4_h_e);
        end
    end

    // stage 6: assemble pixel number
    logic [PIX_W-1:0] r6_pix;
    logic [31:0] pos_p, neg_p, eq_pix, n_pix;
    assign pos_p  = ((32'(r5_irsq) - 32'(r5_ir_p)) << 1) + 32'(r5_ip_p);
    assign neg_p  = 32'(r5_nn) * 32'd12 - ((32'(r5_irsq) + 32'(r5_ir_p)) << 1)
                  + 32'(r5_ip_p);
    assign eq_pix = ((32'(r5_nn) - 32'(r5_ctx.n)) << 1) + (32'(r5_irn) << 2)
                  + 32'(r5_ip_e);
    assign n_pix  = r5_ctx.equ ? eq_pix : (r5_ctx.zpos ? pos_p : neg_p);

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < 6; k++) r_v[k] <= r_v[k-1];
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctx <= i_ctx;
            r1_tmp <= 46'(i_ctx.n) * 46'(i_root);
            r1_t1  <= 49'(i_ctx.n) * 49'(tt4);
            r1_t2  <= 46'(i_ctx.n) * 46'(34'(i_ctx.za) * 34'd3);

            r2_ctx   <= r1_ctx;
            r2_pa_lo <= 62'(tp) * 62'(r1_tmp[31:0]);
            r2_pa_hi <= 44'(tp) * 44'(r1_tmp[45:32]);
            r2_pb_lo <= 63'(omtp) * 63'(r1_tmp[31:0]);
            r2_pb_hi <= 45'(omtp) * 45'(r1_tmp[45:32]);
            r2_jp_e  <= dm_e[49:32];
            r2_jm_e  <= dp_e[49:32];

            r3_ctx  <= r2_ctx;
            r3_jp_p <= sa[77:60];
            r3_jm_p <= sb[77:60];
            r3_jp_e <= r2_jp_e;
            r3_jm_e <= r2_jm_e;
            r3_ir_e <= ir_e;

            r4_ctx  <= r3_ctx;
            r4_ir_p <= (irs_p > 19'(r3_ctx.n)) ? r3_ctx.n : irs_p[RES_W-1:0];
            r4_ir_e <= r3_ir_e;
            r4_h_e  <= s_e[20:1];

            r5_ctx  <= r4_ctx;
            r5_ir_p <= r4_ir_p;
            r5_ip_p <= ttir[45:FRAC_BITS];
            r5_irsq <= 28'(r4_ir_p) * 28'(r4_ir_p);
            r5_nn   <= 27'(r4_ctx.n) * 27'(r4_ctx.n);
            r5_irn  <= 29'(r4_ir_e - 15'd1) * 29'(r4_ctx.n);
            r5_ip_e <= ip_e;

            r6_pix <= n_pix[PIX_W-1:0];
        end
    end

    assign o_valid = r_v[5];
    assign o_pixel = r6_pix;

endmodule

// ----- sv/healpix_ring_direction_to_pixel.sv -----
// HEALPix RING-scheme pixel lookup for one direction per word.
//
// Input channel (i_valid / o_ready): z = cos(theta) in Q2.30, phi in radians in
// Q4.28, sin(theta) in Q1.30 and a flag that selects it near the poles. Output
// channel (o_valid / i_ready): the ring pixel number for the current nside.
// nside is written through i_cfg_we / i_cfg_data while the block is idle; zero
// reads as 1 and values above 8192 saturate.
//
// The datapath is a fixed pipeline: three front stages (phi reduction and the
// squares), a restoring divider and a square-root unit of Q_W / STEPS_PER_STAGE
// stages each, six stages of index arithmetic and one output register. It
// takes one word per cycle while o_ready is high.
//
// Reset clears all valid bits and sets nside to 1. When the receiver stalls,
// the pipeline keeps moving until a skid register behind the output register
// fills; only then does o_ready fall and every stage hold.
module healpix_ring_direction_to_pixel #(
    parameter int STEPS_PER_STAGE = hrdp_pkg::DEF_STEPS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hrdp_pkg::RES_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [hrdp_pkg::Z_W-1:0]   i_cos_colatitude,
    input  logic signed [hrdp_pkg::PHI_W-1:0] i_azimuth,
    input  logic [hrdp_pkg::SIN_W-1:0]        i_sin_colatitude,
    input  logic                              i_sin_valid,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [hrdp_pkg::PIX_W-1:0]        o_pixel_index
);
    import hrdp_pkg::*;

    logic [RES_W-1:0] r_resolution;
    logic             en;

    logic                  f_v;
    logic [DIVIDEND_W-1:0] f_dividend;
    logic [Q_W-1:0]        f_divisor;
    t_dtag                 f_tag;

    logic           d_v;
    logic [Q_W-1:0] d_quot;
    t_dtag          d_tag;
    logic [G_W-1:0] g;

    logic           s_v;
    logic [Q_W-1:0] s_root;
    t_ctx           s_ctx;

    logic             b_v;
    logic [PIX_W-1:0] b_pix;

    logic             r_out_v, r_skid_v;
    logic [PIX_W-1:0] r_out, r_skid;
    logic             push;

    // hold the resolution register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolution <= RES_W'(1);
        end else if (i_cfg_we) begin
            r_resolution <= i_cfg_data;
        end
    end

    assign en      = !r_skid_v;
    assign o_ready = en;
    assign push    = b_v && en;

    hrdp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (i_valid),
        .i_resolution     (r_resolution),
        .i_cos_colatitude (i_cos_colatitude),
        .i_azimuth        (i_azimuth),
        .i_sin_colatitude (i_sin_colatitude),
        .i_sin_valid      (i_sin_valid),
        .o_valid          (f_v),
        .o_dividend       (f_dividend),
        .o_divisor        (f_divisor),
        .o_tag            (f_tag)
    );

    hrdp_div #(
        .STEPS_PER_STAGE (STEPS_PER_STAGE),
        .TAG_W           (DTAG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (f_v),
        .i_dividend (f_dividend),
        .i_divisor  (f_divisor),
        .i_tag      (f_tag),
        .o_valid    (d_v),
        .o_quot     (d_quot),
        .o_tag      (d_tag)
    );

    // pick the near-pole radicand or 3(1-|z|)
    assign g = d_tag.use_div ? d_quot : d_tag.g_lin;

    hrdp_sqrt #(
        .STEPS_PER_STAGE (STEPS_PER_STAGE),
        .TAG_W           (CTX_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (d_v),
        .i_radicand ((2*Q_W)'(g) << 30),
        .i_tag      (d_tag.ctx),
        .o_valid    (s_v),
        .o_root     (s_root),
        .o_tag      (s_ctx)
    );

    hrdp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_v),
        .i_root  (s_root),
        .i_ctx   (s_ctx),
        .o_valid (b_v),
        .o_pixel (b_pix)
    );

    // output register with skid: park a word while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_out_v && !i_ready) begin
            if (push) begin
                r_skid_v <= 1'b1;
            end
        end else if (r_skid_v) begin
            r_out_v  <= 1'b1;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_v && !i_ready) begin
            if (push) begin
                r_skid <= b_pix;
            end
        end else if (r_skid_v) begin
            r_out <= r_skid;
        end else if (push) begin
            r_out <= b_pix;
        end
    end

    assign o_valid       = r_out_v;
    assign o_pixel_index = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held without an output word");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(o_valid && !i_ready))
        else $error("skid filled without a stalled output");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output word present right after reset");

endmodule

// ----- tb/healpix_ring_direction_to_pixel_tb.sv -----
`timescale 1ns / 100ps

module healpix_ring_direction_to_pixel_tb;
    import hrdp_pkg::*;

    localparam int LATENCY = 60;
    localparam longint CYCLE_LIMIT = 400000;

    // Pixel predictor: nside register plus a queue of expected pixel numbers
    class pixel_scoreboard;
        logic [RES_W-1:0] nside_reg;
        logic [PIX_W-1:0] pending_pix[$];
        int errors;
        int checked;

        function new();
            nside_reg = 1;
            errors = 0;
            checked = 0;
        endfunction

        // floor(sqrt(v)) for a 64-bit value, bit by bit
        function automatic longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v -= root + bitv;
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        function automatic logic [PIX_W-1:0] ring_pixel(logic [31:0] z_word,
                logic [31:0] phi_word, logic [30:0] sin_word, logic use_sin);
            longint unsigned n, za, sth, pm, prod, rem, tt, pix;
            logic zneg, zpos;
            n = nside_reg;
            if (n == 0) n = 1;
            if (n > MAX_RESOLUTION) n = MAX_RESOLUTION;
            zneg = z_word[31];
            za = zneg ? (64'd1 << 32) - z_word : z_word;
            zpos = !zneg && z_word != 0;
            if (za > (64'd1 << 30)) za = 64'd1 << 30;
            sth = sin_word;
            if (sth > (64'd1 << 30)) sth = 64'd1 << 30;

            // reduce phi*(2/pi) modulo four quarter turns
            pm = phi_word[31] ? (64'd1 << 32) - phi_word : phi_word;
            prod = pm * 64'hA2F9836E;
            rem = prod & ((64'd1 << 62) - 1);
            if (phi_word[31] && rem != 0) rem = (64'd1 << 62) - rem;
            tt = rem >> (60 - FRAC_BITS);

            if (3 * za <= (64'd1 << 31)) begin
                longint unsigned nl4, ncap, jp, jm, kshift, s, ip;
                longint t1, t2, dm, dp, ir;
                nl4 = 4 * n;
                ncap = 2 * n * (n - 1);
                t1 = longint'(n * (4 * tt + (64'd2 << FRAC_BITS)));
                t2 = 3 * longint'(n) * (zneg ? -longint'(za) : longint'(za));
                dm = t1 - t2;
                dp = t1 + t2;
                if (dm < 0) dm = 0;
                if (dp < 0) dp = 0;
                jp = longint'(unsigned'(dm)) >> (FRAC_BITS + 2);
                jm = longint'(unsigned'(dp)) >> (FRAC_BITS + 2);
                ir = longint'(n) + 1 + longint'(jp) - longint'(jm);
                if (ir < 1) ir = 1;
                if (ir > longint'(2 * n + 1)) ir = 2 * n + 1;
                kshift = 1 - (ir & 1);
                s = jp + jm + kshift + 1 + 2 * nl4 - n;
                ip = (s >> 1) % nl4;
                pix = ncap + (ir - 1) * nl4 + ip;
            end else begin
                longint unsigned one, tp, g, scaled, jp, jm, ir, ip;
                logic [127:0] wide;
                one = 64'd1 << FRAC_BITS;
                tp = tt & (one - 1);
                if (100 * za < 99 * (64'd1 << 30) || !use_sin)
                    g = 3 * ((64'd1 << 30) - za);
                else
                    g = (3 * sth * sth) / ((64'd1 << 30) + za);
                scaled = n * int_sqrt(g << 30);
                wide = 128'(tp) * 128'(scaled);
                jp = 64'(wide >> (FRAC_BITS + 30));
                wide = 128'(one - tp) * 128'(scaled);
                jm = 64'(wide >> (FRAC_BITS + 30));
                ir = jp + jm + 1;
                if (ir > n) ir = n;
                ip = (tt * ir) >> FRAC_BITS;
                if (zpos) pix = 2 * ir * (ir - 1) + ip;
                else pix = 12 * n * n - 2 * ir * (ir + 1) + ip;
            end
            return pix[PIX_W-1:0];
        endfunction

        function void note_direction(logic [31:0] z_word, logic [31:0] phi_word,
                logic [30:0] sin_word, logic use_sin);
            pending_pix.push_back(ring_pixel(z_word, phi_word, sin_word, use_sin));
        endfunction

        function void check_pixel(logic [PIX_W-1:0] got);
            logic [PIX_W-1:0] want;
            checked++;
            if (pending_pix.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel word, expected none, actual %0d", $time, got);
                return;
            end
            want = pending_pix.pop_front();
            if (want !== got) begin
                errors++;
                $display("%0t: pixel_index mismatch, expected %0d, actual %0d",
                         $time, want, got);
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [RES_W-1:0]         i_cfg_data;
    logic                     i_valid;
    logic                     o_ready;
    logic signed [Z_W-1:0]    i_cos_colatitude;
    logic signed [PHI_W-1:0]  i_azimuth;
    logic [SIN_W-1:0]         i_sin_colatitude;
    logic                     i_sin_valid;
    logic                     o_valid;
    logic                     i_ready;
    logic [PIX_W-1:0]         o_pixel_index;

    pixel_scoreboard sb;
    longint cycle_count;
    bit quiet_tail;
    bit long_hold;

    healpix_ring_direction_to_pixel dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cos_colatitude (i_cos_colatitude),
        .i_azimuth        (i_azimuth),
        .i_sin_colatitude (i_sin_colatitude),
        .i_sin_valid      (i_sin_valid),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pixel_index    (o_pixel_index)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // check every pixel word accepted at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_pixel(o_pixel_index);
    end

    // receiver: random stalls in bursts, a long hold on request, none at the tail
    initial begin
        int k;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_ready <= 1'b0;
                for (k = 0; k < 150; k++) @(negedge i_clk);
                long_hold = 0;
                i_ready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                i_ready <= 1'b0;
                for (k = $urandom_range(1, 6); k > 1; k--) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // offer one direction word and hold it until accepted
    task automatic send_direction(logic [31:0] z_word, logic [31:0] phi_word,
            logic [30:0] sin_word, logic use_sin);
        int k;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            for (k = $urandom_range(1, 6); k > 0; k--) @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_cos_colatitude <= z_word;
        i_azimuth        <= phi_word;
        i_sin_colatitude <= sin_word;
        i_sin_valid      <= use_sin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_direction(z_word, phi_word, sin_word, use_sin);
        @(negedge i_clk);
    endtask

    // drop valid and wait out every expected pixel plus the pipeline depth
    task automatic drain_pipeline();
        int k;
        i_valid <= 1'b0;
        while (sb.pending_pix.size() != 0) @(negedge i_clk);
        for (k = 0; k < LATENCY; k++) @(negedge i_clk);
    endtask

    task automatic write_nside(logic [RES_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.nside_reg = value;
    endtask

    // random direction, biased toward caps, poles and the band edges
    task automatic send_random_direction();
        logic [31:0] z_word, phi_word;
        logic [30:0] sin_word;
        case ($urandom_range(0, 5))
            0: z_word = $urandom;
            1: z_word = $urandom_range(0, 32'h4000_0000);
            2: z_word = -$urandom_range(0, 32'h4000_0000);
            3: z_word = ($urandom_range(0, 1) ? 1 : -1) *
                        $urandom_range(32'h3F5C_0000, 32'h4000_0000);
            4: z_word = ($urandom_range(0, 1) ? 1 : -1) *
                        $urandom_range(32'h2AAA_A000, 32'h2AAA_B000);
            default: z_word = ($urandom_range(0, 1) ? 1 : -1) *
                              $urandom_range(0, 32'h2AAA_AAAB);
        endcase
        phi_word = $urandom;
        sin_word = $urandom_range(0, 3) == 0 ? 31'($urandom)
                                             : 31'($urandom_range(0, 32'h0900_0000));
        send_direction(z_word, phi_word, sin_word, 1'($urandom));
    endtask

    initial begin
        logic [RES_W-1:0] nside_list[7];
        int p, j;
        sb = new();
        quiet_tail = 0;
        long_hold = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_cos_colatitude = '0;
        i_azimuth = '0;
        i_sin_colatitude = '0;
        i_sin_valid = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words at reset nside: poles, band edges, phi extremes, sin cases
        send_direction(32'h4000_0000, 32'h0, 31'h0, 1'b0);
        send_direction(32'hC000_0000, 32'h7FFF_FFFF, 31'h0, 1'b1);
        send_direction(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1);
        send_direction(32'h8000_0000, 32'hFFFF_FFFF, 31'h4000_0000, 1'b1);
        send_direction(32'h0, 32'h1921_FB54, 31'h0, 1'b0);
        send_direction(32'h2AAA_AAAA, 32'h3243_F6A8, 31'h0, 1'b0);
        send_direction(32'h2AAA_AAAB, 32'hCDBC_0958, 31'h0, 1'b0);
        send_direction(32'hD555_5556, 32'h1000_0000, 31'h0, 1'b0);
        send_direction(32'h3F5C_28F6, 32'h2000_0000, 31'h0800_0000, 1'b1);
        send_direction(32'h3F5C_28F5, 32'h2000_0000, 31'h0800_0000, 1'b1);
        send_direction(32'hC0A3_D70A, 32'hE000_0000, 31'h0100_0000, 1'b1);
        send_direction(32'h3FFF_FFFF, 32'h0000_0001, 31'h0000_8000, 1'b1);
        drain_pipeline();

        // nside zero, maximum, above maximum, odd and small values
        nside_list = '{14'd0, 14'd8192, 14'd16383, 14'd3, 14'd1000, 14'd7, 14'd2};
        for (p = 0; p < 7; p++) begin
            write_nside(nside_list[p]);
            send_direction(32'h4000_0000, 32'h7FFF_FFFF, 31'h0, 1'b0);
            send_direction(32'hBFFF_FFFF, 32'h8000_0000, 31'h4000_0000, 1'b1);
            if (p == 1) begin
                // fill the pipeline against a long receiver hold
                long_hold = 1;
                for (j = 0; j < 120; j++) send_random_direction();
            end else begin
                for (j = 0; j < 260; j++) send_random_direction();
            end
            // sender waits for every result
            drain_pipeline();
        end

        // tail without idling on either side
        write_nside($urandom_range(1, 64));
        quiet_tail = 1;
        for (j = 0; j < 120; j++) send_random_direction();
        drain_pipeline();

        $display("Covered %0d pixel words over nside 0, 1, 2, 3, 7, 1000, 8192, 16383",
                 sb.checked);
        $display("and a random tail value, with equator, cap, near-pole and stall cases.");
        if (sb.errors == 0 && sb.pending_pix.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- healpix_ring_direction_to_pixel.f -----
sv/hrdp_pkg.sv
sv/hrdp_front.sv
sv/hrdp_div.sv
sv/hrdp_sqrt.sv
sv/hrdp_back.sv
sv/healpix_ring_direction_to_pixel.sv
tb/healpix_ring_direction_to_pixel_tb.sv
